// File: rtl/isort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and constants for the insertion sort engine.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    // top level sequencing
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } isort_state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;      // place incoming value into the sorted row
        logic shift;       // move the row one cell toward the head
        logic descending;  // order select
    } cell_ctrl_t;

endpackage

// File: rtl/isort_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorted row: holds a value, decides where an incoming
// value lands and hands data to its neighbors.
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  isort_pkg::cell_ctrl_t         ctrl,
    input  logic [isort_pkg::DATA_W-1:0]  new_value,
    // neighbor toward the head
    input  logic                          left_ins,
    input  logic                          left_valid,
    input  logic [isort_pkg::DATA_W-1:0]  left_value,
    // neighbor toward the tail
    input  logic                          right_valid,
    input  logic [isort_pkg::DATA_W-1:0]  right_value,
    // own state
    output logic                          ins,
    output logic                          valid,
    output logic [isort_pkg::DATA_W-1:0]  value
);
    import isort_pkg::*;

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              goes_after;

    // stored value belongs after the incoming one
    always_comb begin
        if (ctrl.descending) begin
            goes_after = $signed(value_reg) < $signed(new_value);
        end else begin
            goes_after = $signed(value_reg) > $signed(new_value);
        end
    end

    assign ins = !valid_reg || goes_after;

    // insert: take new value or the left neighbor's; drain: take the right's
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert && ins) begin
            if (left_ins) begin
                valid_next = left_valid;
                value_next = left_value;
            end else begin
                valid_next = 1'b1;
                value_next = new_value;
            end
        end else if (ctrl.shift) begin
            valid_next = right_valid;
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

// File: rtl/introspective_sort_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// introspective_sort_engine
// Collects a set of signed values, keeps them ordered in a row of cells and
// streams them out in sorted order after the last beat of the set.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata               | tlast         | tuser
//  s_       | in  | [31:0] value        | final_item    | -
//  m_       | out | [31:0] sorted_value | final_result  | overflowed
//  cfg_     | in  | [0] descending      | -             | -
//
//  Load: one input beat per cycle; each beat is placed in the row in the
//  same cycle. After the closing beat, n result beats follow at one per
//  cycle (n = stored count) unless m_tready holds the output register.
//  s_tready is low while a set drains; the output register lets a new set
//  load while the final result beat still waits on m_tready.
//  Reset empties the row; beats beyond CAPACITY are dropped and flagged.
// ----------------------------------------------------------------------------
module introspective_sort_engine #(
    parameter int CAPACITY = isort_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,   // [0] descending
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [isort_pkg::DATA_W-1:0] s_tdata,       // [31:0] value
    input  logic                         s_tlast,       // final_item
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [isort_pkg::DATA_W-1:0] m_tdata,       // [31:0] sorted_value
    output logic                         m_tlast,       // final_result
    output logic                         m_tuser        // [0] overflowed
);
    import isort_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    isort_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              drain_ovf_reg, drain_ovf_next;
    logic              descending_reg;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    logic              in_beat;
    logic              full;
    logic              pop;
    cell_ctrl_t        ctrl;

    logic              cell_ins   [CAPACITY];
    logic              cell_valid [CAPACITY];
    logic [DATA_W-1:0] cell_value [CAPACITY];

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            descending_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            descending_reg <= cfg_wr_data;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign in_beat  = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign pop      = (state_reg == ST_DRAIN) && (!m_valid_reg || m_tready);

    assign ctrl.insert     = in_beat && !full;
    assign ctrl.shift      = pop;
    assign ctrl.descending = descending_reg;

    // row of cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic              l_ins, l_valid, r_valid;
        logic [DATA_W-1:0] l_value, r_value;

        if (i == 0) begin : g_head
            assign l_ins   = 1'b0;
            assign l_valid = 1'b0;
            assign l_value = '0;
        end else begin : g_body
            assign l_ins   = cell_ins[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_value = '0;
        end else begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_value = cell_value[i+1];
        end

        isort_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_value   (s_tdata),
            .left_ins    (l_ins),
            .left_valid  (l_valid),
            .left_value  (l_value),
            .right_valid (r_valid),
            .right_value (r_value),
            .ins         (cell_ins[i]),
            .valid       (cell_valid[i]),
            .value       (cell_value[i])
        );
    end

    // sequencing and output register
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        drain_ovf_next = drain_ovf_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_beat) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        drain_ovf_next = ovf_reg || full;
                        state_next     = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (pop) begin
                    m_valid_next = 1'b1;
                    m_data_next  = cell_value[0];
                    m_last_next  = !cell_valid[1];
                    m_user_next  = drain_ovf_reg;
                    if (!cell_valid[1]) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            drain_ovf_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            drain_ovf_reg <= drain_ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: rtl/isort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_checker
// Port-level checks of the sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module isort_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [isort_pkg::DATA_W-1:0] m_tdata,
    input logic                         m_tlast,
    input logic                         m_tuser
);

    // stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // closing beat starts the drain, input closes
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after closing beat");

    // no input taken while a set is only partly out
    a_mid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open in the middle of a set");

    // reset leaves no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind introspective_sort_engine isort_checker u_isort_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of introspective_sort_engine. Sets of signed values are
// sent on s_, each closed by tlast. A model in the monitor collects the set,
// orders it by the current order select and queues the result beats it
// expects. Every m_ beat is checked field by field against that queue. The
// run covers corner values in both orders, store overflow, random sets under
// several idle and stall mixes, and a long output hold that fills the engine.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAPACITY    = isort_pkg::CAPACITY_DEF;
    localparam int DW          = isort_pkg::DATA_W;
    localparam int LONG_HOLD   = 300;    // output hold-off, in cycles
    localparam int QUIET_LIMIT = 3000;   // cycles with no beat before giving up
    localparam int SETTLE      = 8;      // quiet cycles before a config write
    localparam int END_WAIT    = 40;
    localparam int PHASE_ITEMS = 20;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
        logic          dropped;
    } sorted_beat_t;

    logic          aclk        = 1'b0;
    logic          aresetn     = 1'b0;
    logic          cfg_wr_en   = 1'b0;
    logic          cfg_wr_data = 1'b0;
    logic          s_tvalid    = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata     = '0;
    logic          s_tlast     = 1'b0;
    logic          m_tvalid;
    logic          m_tready    = 1'b0;
    logic [DW-1:0] m_tdata;
    logic          m_tlast;
    logic          m_tuser;

    // stimulus knobs
    int            src_gap_pct    = 0;
    int            sink_stall_pct = 0;
    logic          hold_on        = 1'b0;
    int            hold_cnt       = 0;

    // model state
    logic                 order_desc  = 1'b0;
    logic signed [DW-1:0] set_vals [CAPACITY];
    int                   set_count   = 0;
    logic                 set_dropped = 1'b0;
    sorted_beat_t         pending [$];

    int errors       = 0;
    int quiet_cycles = 0;

    introspective_sort_engine #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [31:0] value
        .s_tlast     (s_tlast),      // final_item
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // [31:0] sorted_value
        .m_tlast     (m_tlast),      // final_result
        .m_tuser     (m_tuser)       // [0] overflowed
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side ready: random stall, or a long hold counted here
    always @(posedge aclk) begin
        if (hold_on && hold_cnt < LONG_HOLD) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (!hold_on)
                hold_cnt <= 0;
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // model and checker, sampled at the edge
    always @(posedge aclk) begin : monitor
        int                   i;
        int                   j;
        logic signed [DW-1:0] key;
        sorted_beat_t         beat;
        sorted_beat_t         want;

        if (aresetn) begin
            if (cfg_wr_en)
                order_desc = cfg_wr_data;

            if (s_tvalid && s_tready) begin
                if (set_count < CAPACITY) begin
                    set_vals[set_count] = s_tdata;
                    set_count++;
                end else begin
                    set_dropped = 1'b1;
                end
                // closing beat: order the set and queue its results
                if (s_tlast) begin
                    for (i = 1; i < set_count; i++) begin
                        key = set_vals[i];
                        j   = i;
                        while (j > 0 && (order_desc ? (set_vals[j-1] < key)
                                                    : (set_vals[j-1] > key))) begin
                            set_vals[j] = set_vals[j-1];
                            j--;
                        end
                        set_vals[j] = key;
                    end
                    for (i = 0; i < set_count; i++) begin
                        beat.value   = set_vals[i];
                        beat.last    = (i == set_count - 1);
                        beat.dropped = set_dropped;
                        pending.push_back(beat);
                    end
                    set_count   = 0;
                    set_dropped = 1'b0;
                end
            end

            if (m_tvalid && m_tready) begin
                if (pending.size() == 0) begin
                    $display("%0t: result beat %h with nothing expected", $time, m_tdata);
                    errors++;
                end else begin
                    want = pending.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t: sorted_value expected %h got %h",
                                 $time, want.value, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: final_result expected %b got %b",
                                 $time, want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.dropped) begin
                        $display("%0t: overflowed expected %b got %b",
                                 $time, want.dropped, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog: stop when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // extremes, small values for duplicates, or anything
    function automatic logic [DW-1:0] rand_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DW-1:0] corner_value(input int idx);
        case (idx)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h8000_0000;
            6:       return 32'h7FFF_FFFF;
            7:       return 32'h0000_0005;
            8:       return 32'h0000_0005;
            default: return 32'hFFFF_FFFB;
        endcase
    endfunction

    // one input beat; called and returns at a rising edge
    task automatic send_beat(input logic [DW-1:0] value, input logic last);
        if ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++)
            send_beat(rand_value(), k == n - 1);
    endtask

    // stop sending and let every expected result arrive
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_order(input logic desc);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= desc;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input int gap, input int stall);
        src_gap_pct     = gap;
        sink_stall_pct <= stall;
    endtask

    // single-value set, then extremes, zero, +-1 and repeats in one set
    task automatic test_corner_values(input logic desc);
        set_order(desc);
        send_beat('0, 1'b1);
        for (int k = 0; k < 10; k++)
            send_beat(corner_value(k), k == 9);
    endtask

    // exactly full, one past full with the closing beat dropped, well past full, then a short set
    task automatic test_store_full();
        set_order(1'b0);
        send_set(CAPACITY);
        send_set(CAPACITY + 1);
        set_order(1'b1);
        send_set(CAPACITY + 6);
        send_set(3);
    endtask

    // random sets, mostly short, under each idle mix
    task automatic test_random_sets();
        int sent;
        int n;
        int r;
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0:       set_idling(0, 0);
                1:       set_idling(63, 0);
                2:       set_idling(0, 63);
                default: set_idling(12, 12);
            endcase
            set_order(mode[0] ^ 1'($urandom_range(1)));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 70)
                    n = $urandom_range(12, 1);
                else if (r < 92)
                    n = $urandom_range(CAPACITY, 13);
                else
                    n = $urandom_range(CAPACITY + 6, CAPACITY - 4);
                send_set(n);
                sent += n;
            end
        end
    endtask

    // hold the result side long enough that the engine stops taking input
    task automatic test_output_hold();
        set_order(1'b0);
        set_idling(0, 0);
        hold_on <= 1'b1;
        send_set(CAPACITY);
        send_set(12);
        wait_drained();
        hold_on <= 1'b0;
        send_set(5);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_corner_values(1'b0);
        test_corner_values(1'b1);
        test_store_full();
        test_random_sets();
        test_output_hold();

        wait_drained();
        repeat (END_WAIT) @(posedge aclk);
        if (pending.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, pending.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
